// ===== rtl/chwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chwc_pkg: compass heading shared definitions
// Widths, CORDIC arctangent table, heading constants and the calibration
// status bundle passed from the calibration unit to the sequencer.
// ----------------------------------------------------------------------------
package chwc_pkg;

  // Sample and iteration sizing
  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int TAB_LEN      = 24;

  // CORDIC datapath: magnitudes scaled up to bit 40, plus gain headroom and sign
  localparam int SCALE = 40 - SAMPLE_BITS;
  localparam int CW    = 43;
  // Angle accumulator in tenths of a degree times 2^16
  localparam int ZW    = 28;
  localparam int HW    = 29;
  localparam int FRAC  = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT  = 2'd2;
  localparam logic [15:0]          CAL_COUNT_RST  = 16'd500;

  // Input operation codes
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_CAL_START = 1'b1;

  // Heading output
  localparam int HEAD_W = 12;
  localparam logic [HEAD_W-1:0] HEAD_EAST  = 12'd0;
  localparam logic [HEAD_W-1:0] HEAD_NORTH = 12'd900;
  localparam logic [HEAD_W-1:0] HEAD_WEST  = 12'd1800;
  localparam logic [HEAD_W-1:0] HEAD_SOUTH = 12'd2700;

  localparam logic signed [HW-1:0] QUARTER = HW'(900 * 65536);
  localparam logic signed [ZW-1:0] Z_MIN   = ZW'(1);
  localparam logic signed [ZW-1:0] Z_MAX   = ZW'(900 * 65536 - 1);

  // atan(2^-i) in tenths of a degree times 2^16, rounded to nearest
  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    28'sd29491200, 28'sd17409672, 28'sd9198793, 28'sd4669451,
    28'sd2343786,  28'sd1173036,  28'sd586661,  28'sd293348,
    28'sd146676,   28'sd73339,    28'sd36669,   28'sd18335,
    28'sd9167,     28'sd4584,     28'sd2292,    28'sd1146,
    28'sd573,      28'sd286,      28'sd143,     28'sd72,
    28'sd36,       28'sd18,       28'sd9,       28'sd4
  };

  // Calibration status toward the sequencer
  typedef struct packed {
    logic                          active;
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] off_x;
    logic signed [SAMPLE_BITS-1:0] off_y;
  } cal_stat_t;

endpackage

// ===== rtl/chwc_cal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chwc_cal: hard-iron calibration unit
// Tracks per-axis min/max during calibration, counts down the sample budget,
// and owns the live offsets (loaded by config writes or calibration end).
// ----------------------------------------------------------------------------
module chwc_cal (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    accept_i,
  input  logic                                    op_i,
  input  logic signed [chwc_pkg::SAMPLE_BITS-1:0] mag_x_i,
  input  logic signed [chwc_pkg::SAMPLE_BITS-1:0] mag_y_i,
  input  logic                                    cfg_we_i,
  input  logic [chwc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [15:0]                             cfg_data_i,
  output chwc_pkg::cal_stat_t                     stat_o
);

  localparam int SB = chwc_pkg::SAMPLE_BITS;

  logic signed [SB-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [SB-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  logic signed [SB-1:0] off_x_q, off_y_q, off_x_d, off_y_d;
  logic [15:0]          count_q, count_d, budget_q, budget_d;
  logic                 active_q, active_d, done_q, done_d;
  logic signed [SB-1:0] nmin_x, nmax_x, nmin_y, nmax_y;
  logic signed [SB:0]   sum_x, sum_y;

  // Extremes including the current sample
  always_comb begin
    nmin_x = (mag_x_i < min_x_q) ? mag_x_i : min_x_q;
    nmax_x = (mag_x_i > max_x_q) ? mag_x_i : max_x_q;
    nmin_y = (mag_y_i < min_y_q) ? mag_y_i : min_y_q;
    nmax_y = (mag_y_i > max_y_q) ? mag_y_i : max_y_q;
    sum_x  = (SB+1)'(nmin_x) + (SB+1)'(nmax_x);
    sum_y  = (SB+1)'(nmin_y) + (SB+1)'(nmax_y);
  end

  // Next-state for config writes and accepted words
  always_comb begin
    min_x_d  = min_x_q;
    max_x_d  = max_x_q;
    min_y_d  = min_y_q;
    max_y_d  = max_y_q;
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;
    count_d  = count_q;
    budget_d = budget_q;
    active_d = active_q;
    done_d   = done_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        chwc_pkg::REG_OFFSET_X:  off_x_d  = SB'(cfg_data_i);
        chwc_pkg::REG_OFFSET_Y:  off_y_d  = SB'(cfg_data_i);
        chwc_pkg::REG_CAL_COUNT: budget_d = cfg_data_i;
        default: ;
      endcase
    end
    if (accept_i) begin
      done_d = 1'b0;
      if (op_i == chwc_pkg::OP_CAL_START) begin
        active_d = 1'b1;
        min_x_d  = '0;
        max_x_d  = '0;
        min_y_d  = '0;
        max_y_d  = '0;
        count_d  = budget_q;
      end else if (active_q) begin
        min_x_d = nmin_x;
        max_x_d = nmax_x;
        min_y_d = nmin_y;
        max_y_d = nmax_y;
        if (count_q != '0) begin
          count_d = count_q - 16'd1;
        end else begin
          // Midpoint, truncated toward zero
          active_d = 1'b0;
          done_d   = 1'b1;
          off_x_d  = SB'((sum_x + (SB+1)'(sum_x[SB])) >>> 1);
          off_y_d  = SB'((sum_y + (SB+1)'(sum_y[SB])) >>> 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q  <= '0;
      max_x_q  <= '0;
      min_y_q  <= '0;
      max_y_q  <= '0;
      off_x_q  <= '0;
      off_y_q  <= '0;
      count_q  <= '0;
      budget_q <= chwc_pkg::CAL_COUNT_RST;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      min_x_q  <= min_x_d;
      max_x_q  <= max_x_d;
      min_y_q  <= min_y_d;
      max_y_q  <= max_y_d;
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      count_q  <= count_d;
      budget_q <= budget_d;
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  assign stat_o.active = active_q;
  assign stat_o.done   = done_q;
  assign stat_o.off_x  = off_x_q;
  assign stat_o.off_y  = off_y_q;

endmodule

// ===== rtl/chwc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chwc_cordic: iterative vectoring CORDIC
// One shift-add step per cycle on shared registers; returns the first-quadrant
// angle of (|x|, |y|) in tenths of a degree times 2^16.
// ----------------------------------------------------------------------------
module chwc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [chwc_pkg::SAMPLE_BITS-1:0]    mag_x_i,
  input  logic [chwc_pkg::SAMPLE_BITS-1:0]    mag_y_i,
  output logic                                done_o,
  output logic signed [chwc_pkg::ZW-1:0]      z_o
);

  localparam int CW = chwc_pkg::CW;
  localparam int ZW = chwc_pkg::ZW;
  localparam int SW = chwc_pkg::STEP_W;
  localparam int TW = $clog2(chwc_pkg::TAB_LEN);

  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q;
  logic [SW-1:0]        step_q;
  logic                 busy_q, done_q, last;

  // Shared shifter: floor shift by the step index
  always_comb begin
    dx   = y_q >>> step_q;
    dy   = x_q >>> step_q;
    last = (step_q == SW'(chwc_pkg::CORDIC_STEPS - 1));
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + SW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: load scaled magnitudes, then rotate toward the x axis
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= signed'(CW'(mag_x_i) << chwc_pkg::SCALE);
      y_q <= signed'(CW'(mag_y_i) << chwc_pkg::SCALE);
      z_q <= '0;
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + chwc_pkg::ATAN_TAB[TW'(step_q)];
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - chwc_pkg::ATAN_TAB[TW'(step_q)];
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

// ===== rtl/compass_heading_with_calibration.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_with_calibration: magnetometer heading with hard-iron cal
// Offset-corrects each X/Y sample, runs an iterative CORDIC atan2 and
// reports the heading in tenths of a degree plus calibration status.
//
//  channel  direction  handshake             payload
//  in       input      in_valid_i/in_ready_o op, mag_x, mag_y
//  out      output     out_valid_o/out_ready_i heading, calibrating, done, offsets
//  cfg      input      cfg_we_i              cfg_idx_i, cfg_data_i
//
//  A sample passes from accept through a correction state (ST_PREP), the
//  CORDIC run (ST_RUN, one CORDIC step per cycle in the shared shift-add
//  unit, until its finish is seen) and a result state (ST_FIN) that waits
//  for a free output register; the next word is taken after that. A start
//  command goes straight to ST_FIN; a zero-axis sample skips the CORDIC.
//  One word is in work at a time; in_ready_o is high only when idle, and a
//  new word may be taken while the previous result waits in the output register.
//  Reset clears control, calibration state and offsets; calib count resets to 500.
// ----------------------------------------------------------------------------
module compass_heading_with_calibration (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     op_i,
  input  logic signed [chwc_pkg::SAMPLE_BITS-1:0]  mag_x_i,
  input  logic signed [chwc_pkg::SAMPLE_BITS-1:0]  mag_y_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [chwc_pkg::HEAD_W-1:0]              heading_tenths_o,
  output logic                                     calibrating_o,
  output logic                                     calib_done_o,
  output logic signed [chwc_pkg::SAMPLE_BITS-1:0]  offset_x_out_o,
  output logic signed [chwc_pkg::SAMPLE_BITS-1:0]  offset_y_out_o,
  input  logic                                     cfg_we_i,
  input  logic [chwc_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [15:0]                              cfg_data_i
);

  localparam int SB = chwc_pkg::SAMPLE_BITS;
  localparam int HW = chwc_pkg::HW;
  localparam int ZW = chwc_pkg::ZW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  chwc_pkg::cal_stat_t  cal_stat;
  logic                 accept, out_free, cor_start, cor_done;
  logic signed [SB-1:0] mag_x_q, mag_y_q, cx, cy;
  logic [SB-1:0]        abs_x, abs_y;
  logic signed [ZW-1:0] z, z_c;
  logic signed [HW-1:0] h;
  logic                 sx_q, sy_q, fixed_q;
  logic [chwc_pkg::HEAD_W-1:0] fixed_head_q, head;
  logic                 out_valid_q;
  logic [chwc_pkg::HEAD_W-1:0] head_q;
  logic                 cal_q, done_q;
  logic signed [SB-1:0] offx_q, offy_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  chwc_cal u_cal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .mag_x_i    (mag_x_i),
    .mag_y_i    (mag_y_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_o     (cal_stat)
  );

  // Offset correction with wrap, and axis magnitudes
  always_comb begin
    cx    = mag_x_q - cal_stat.off_x;
    cy    = mag_y_q - cal_stat.off_y;
    abs_x = cx[SB-1] ? SB'(-cx) : SB'(cx);
    abs_y = cy[SB-1] ? SB'(-cy) : SB'(cy);
  end

  assign cor_start = (state_q == ST_PREP) && (cx != '0) && (cy != '0);

  chwc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .mag_x_i (abs_x),
    .mag_y_i (abs_y),
    .done_o  (cor_done),
    .z_o     (z)
  );

  // Clamp the first-quadrant angle and map it to its quadrant
  always_comb begin
    z_c = z;
    if (z < chwc_pkg::Z_MIN) begin
      z_c = chwc_pkg::Z_MIN;
    end else if (z > chwc_pkg::Z_MAX) begin
      z_c = chwc_pkg::Z_MAX;
    end
    if (!sx_q && !sy_q) begin
      h = HW'(z_c);
    end else if (sx_q && !sy_q) begin
      h = (chwc_pkg::QUARTER <<< 1) - HW'(z_c);
    end else if (sx_q) begin
      h = (chwc_pkg::QUARTER <<< 1) + HW'(z_c);
    end else begin
      h = (chwc_pkg::QUARTER <<< 2) - HW'(z_c);
    end
    head = fixed_q ? fixed_head_q
                   : h[chwc_pkg::FRAC +: chwc_pkg::HEAD_W];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (op_i == chwc_pkg::OP_CAL_START) ? ST_FIN : ST_PREP;
        end
      end
      ST_PREP: state_d = cor_start ? ST_RUN : ST_FIN;
      ST_RUN:  if (cor_done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the sample, settle zero-axis cases, load the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_x_q      <= mag_x_i;
      mag_y_q      <= mag_y_i;
      fixed_q      <= 1'b1;
      fixed_head_q <= chwc_pkg::HEAD_EAST;
    end
    if (state_q == ST_PREP) begin
      sx_q    <= cx[SB-1];
      sy_q    <= cy[SB-1];
      fixed_q <= !cor_start;
      if (cy == '0) begin
        fixed_head_q <= cx[SB-1] ? chwc_pkg::HEAD_WEST : chwc_pkg::HEAD_EAST;
      end else begin
        fixed_head_q <= cy[SB-1] ? chwc_pkg::HEAD_SOUTH : chwc_pkg::HEAD_NORTH;
      end
    end
    if (state_q == ST_FIN && out_free) begin
      head_q <= head;
      cal_q  <= cal_stat.active;
      done_q <= cal_stat.done;
      offx_q <= cal_stat.off_x;
      offy_q <= cal_stat.off_y;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign heading_tenths_o = head_q;
  assign calibrating_o    = cal_q;
  assign calib_done_o     = done_q;
  assign offset_x_out_o   = offx_q;
  assign offset_y_out_o   = offy_q;

endmodule
